/* design/rolling_xor_packet_codec_defines.svh */
// ----------------------------------------------------------------------------
// rolling_xor_packet_codec_defines
// assertion macros shared by the codec checker
// ----------------------------------------------------------------------------
`ifndef ROLLING_XOR_PACKET_CODEC_DEFINES_SVH
`define ROLLING_XOR_PACKET_CODEC_DEFINES_SVH

// implication that holds in every cycle, reset included
`define RXPC_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

// same-cycle implication, checked outside reset
`define RXPC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define RXPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/rxpc_pkg.sv */
// ----------------------------------------------------------------------------
// rxpc_pkg
// types and register codes of the rolling xor packet codec
// ----------------------------------------------------------------------------
package rxpc_pkg;

  localparam int ByteW = 8;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FIXED_KEY   = 1'b0,
    CFG_DECODE_MODE = 1'b1
  } cfg_index_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [ByteW-1:0] fixed_key;
    logic             decode_mode;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
    logic [ByteW-1:0] rand_key;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             end_of_packet;
    logic             checksum_ok;
  } out_item_t;

endpackage

/* design/rolling_xor_packet_codec.sv */
// ----------------------------------------------------------------------------
// rolling_xor_packet_codec
// chained two-key xor packet encoder/decoder with sum8 checksum check
//
//   channel  dir  fields (tdata / tlast / tuser)
//   s_*      in   {rand_key, data_byte} / last_byte / first_byte
//   m_*      out  out_byte / end_of_packet / checksum_ok
//   cfg_*    in   cfg_index selects fixed_key or decode_mode, cfg_data value
//
// one byte per cycle sustained while m_tready is not held low; an item is
// captured in the input register and moves to the result register when free.
// the chain update is a single combinational add/xor pass.
// rst is synchronous and clears chains, index, keys, sum and both valid flags.
// a stall on m_tready holds the result; one more item waits in the input stage.
// ----------------------------------------------------------------------------
module rolling_xor_packet_codec (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] rand_key
  input  logic        s_tlast,
  input  logic [0:0]  s_tuser,   // [0] first_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // [0] checksum_ok
  // configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rxpc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  held_item;
  out_item_t result;
  out_item_t out_item;
  logic      out_free;
  logic      advance;

  // unpack input transfer
  always_comb begin
    in_item.data_byte  = s_tdata[7:0];
    in_item.rand_key   = s_tdata[15:8];
    in_item.first_byte = s_tuser[0];
    in_item.last_byte  = s_tlast;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_key   <= '0;
      cfg.decode_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FIXED_KEY:   cfg.fixed_key   <= cfg_data;
        CFG_DECODE_MODE: cfg.decode_mode <= cfg_data[0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  rxpc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_free  (out_free),
    .advance   (advance),
    .held_item (held_item)
  );

  rxpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .result  (result)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_tdata    = out_item.out_byte;
  assign m_tlast    = out_item.end_of_packet;
  assign m_tuser[0] = out_item.checksum_ok;

endmodule

/* design/rxpc_in_stage.sv */
// ----------------------------------------------------------------------------
// rxpc_in_stage
// input register of the codec; hands an item on when the result slot frees
// ----------------------------------------------------------------------------
module rxpc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rxpc_pkg::in_item_t in_item,
  input  logic              out_free,
  output logic              advance,
  output rxpc_pkg::in_item_t held_item
);
  import rxpc_pkg::*;

  logic     valid;
  in_item_t item;

  // move the held item into the datapath when the result register can take it
  assign advance   = valid && out_free;
  assign in_ready  = !valid || advance;
  assign held_item = item;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* design/rxpc_core.sv */
// ----------------------------------------------------------------------------
// rxpc_core
// two-chain xor datapath with packet state and checksum tracking
// ----------------------------------------------------------------------------
module rxpc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  rxpc_pkg::in_item_t item,
  input  rxpc_pkg::cfg_t     cfg,
  output rxpc_pkg::out_item_t result
);
  import rxpc_pkg::*;

  logic [ByteW-1:0] byte_index;
  logic [ByteW-1:0] rand_chain;
  logic [ByteW-1:0] fixed_chain;
  logic [ByteW-1:0] latched_rand_key;
  logic [ByteW-1:0] stored_checksum;
  logic [ByteW-1:0] payload_sum;

  logic [ByteW-1:0] rc, fc, idx, key, n, ka, kb;
  logic [ByteW-1:0] mid, plain, cipher;
  logic [ByteW-1:0] stored_checksum_next, payload_sum_next;

  // a first byte restarts chains, index and sum
  always_comb begin
    rc  = item.first_byte ? '0 : rand_chain;
    fc  = item.first_byte ? '0 : fixed_chain;
    idx = item.first_byte ? '0 : byte_index;
    key = item.first_byte ? item.rand_key : latched_rand_key;
    n   = idx + 8'd1;
    ka  = rc + key + n;
    kb  = fc + cfg.fixed_key + n;
  end

  // encode or decode through both chains
  always_comb begin
    if (cfg.decode_mode) begin
      cipher = item.data_byte;
      mid    = cipher ^ kb;
      plain  = mid ^ ka;
    end else begin
      plain  = item.data_byte;
      mid    = plain ^ ka;
      cipher = mid ^ kb;
    end
  end

  // checksum byte on first, running sum otherwise
  always_comb begin
    if (item.first_byte) begin
      stored_checksum_next = plain;
      payload_sum_next     = '0;
    end else begin
      stored_checksum_next = stored_checksum;
      payload_sum_next     = payload_sum + plain;
    end
  end

  // result fields
  always_comb begin
    result.out_byte      = cfg.decode_mode ? plain : cipher;
    result.end_of_packet = item.last_byte;
    result.checksum_ok   = item.last_byte && (stored_checksum_next == payload_sum_next);
  end

  // packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      rand_chain       <= '0;
      fixed_chain      <= '0;
      latched_rand_key <= '0;
      stored_checksum  <= '0;
      payload_sum      <= '0;
    end else if (advance) begin
      byte_index       <= n;
      rand_chain       <= mid;
      fixed_chain      <= cipher;
      latched_rand_key <= key;
      stored_checksum  <= stored_checksum_next;
      payload_sum      <= payload_sum_next;
    end
  end

endmodule

/* design/rxpc_checker.sv */
// ----------------------------------------------------------------------------
// rxpc_checker
// port-level checks of the rolling xor packet codec
// ----------------------------------------------------------------------------
`include "rolling_xor_packet_codec_defines.svh"

module rxpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  // reset empties the result register
  `RXPC_ASSERT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result valid right after reset")

  // checksum flag only rides on the last byte of a packet
  `RXPC_ASSERT_NOW(a_ok_on_last, m_tvalid && m_tuser[0], m_tlast, "checksum_ok without tlast")

  // a stalled result stays offered
  `RXPC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")

  // a stalled result keeps its payload
  `RXPC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready,
    $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed under stall")

endmodule

bind rolling_xor_packet_codec rxpc_checker u_rxpc_checker (.*);

/* dv/rxpc_codec_tb_pkg.sv */
// ----------------------------------------------------------------------------
// rxpc_codec_tb_pkg
// scoreboard for the rolling xor packet codec: predicts each result from the
// accepted input bytes and the register settings, then checks results in order
// ----------------------------------------------------------------------------
package rxpc_codec_tb_pkg;

  import rxpc_pkg::*;

  // chain state carried from byte to byte
  typedef struct {
    logic [7:0] prev_index;
    logic [7:0] rand_chain;
    logic [7:0] fixed_chain;
    logic [7:0] rand_key;
    logic [7:0] checksum;
    logic [7:0] payload_sum;
  } chain_state_t;

  class codec_scoreboard;
    logic [7:0]   fixed_key;
    logic         decode_mode;
    chain_state_t chain;
    out_item_t    expected_bytes[$];
    int           mismatches;

    function new();
      fixed_key   = '0;
      decode_mode = 1'b0;
      chain       = '{default: '0};
      mismatches  = 0;
    endfunction

    function void apply_setting(cfg_index_t idx, logic [7:0] value);
      case (idx)
        CFG_FIXED_KEY:   fixed_key = value;
        CFG_DECODE_MODE: decode_mode = value[0];
        default: ;
      endcase
    endfunction

    // one byte through both xor chains, all sums wrap at 8 bits
    function out_item_t code_byte(inout chain_state_t st, input in_item_t item,
                                  input logic decode, input logic [7:0] fkey);
      logic [7:0] n, rand_mask, fixed_mask, mid, plain, cipher;
      out_item_t  res;
      if (item.first_byte) begin
        st.rand_chain  = '0;
        st.fixed_chain = '0;
        st.prev_index  = '0;
        st.payload_sum = '0;
        st.rand_key    = item.rand_key;
      end
      n          = st.prev_index + 8'd1;
      rand_mask  = st.rand_chain + st.rand_key + n;
      fixed_mask = st.fixed_chain + fkey + n;
      if (decode) begin
        cipher       = item.data_byte;
        mid          = cipher ^ fixed_mask;
        plain        = mid ^ rand_mask;
        res.out_byte = plain;
      end else begin
        plain        = item.data_byte;
        mid          = plain ^ rand_mask;
        cipher       = mid ^ fixed_mask;
        res.out_byte = cipher;
      end
      st.rand_chain  = mid;
      st.fixed_chain = cipher;
      st.prev_index  = n;
      if (item.first_byte) begin
        st.checksum = plain;
      end else begin
        st.payload_sum = st.payload_sum + plain;
      end
      res.end_of_packet = item.last_byte;
      res.checksum_ok   = item.last_byte && (st.checksum == st.payload_sum);
      return res;
    endfunction

    function void note_input(in_item_t item);
      expected_bytes.push_back(code_byte(chain, item, decode_mode, fixed_key));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: byte %02h eop %0b ok %0b",
                   got.out_byte, got.end_of_packet, got.checksum_ok);
        end
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.end_of_packet !== want.end_of_packet ||
          got.checksum_ok !== want.checksum_ok) begin
        if (mismatches < 10) begin
          $display("mismatch: expected byte %02h eop %0b ok %0b, got byte %02h eop %0b ok %0b",
                   want.out_byte, want.end_of_packet, want.checksum_ok,
                   got.out_byte, got.end_of_packet, got.checksum_ok);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

endpackage

/* dv/tb_rolling_xor_packet_codec.sv */
// ----------------------------------------------------------------------------
// tb_rolling_xor_packet_codec
// self-checking testbench for the rolling xor packet codec: directed corner
// bytes, then random well-formed, broken and stray packets in both modes
// under several key settings and idle/stall mixes, checked by a scoreboard
// ----------------------------------------------------------------------------
module tb_rolling_xor_packet_codec;

  import rxpc_pkg::*;
  import rxpc_codec_tb_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 120;
  localparam int PhaseItems  = 55;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [7:0] data_byte, [15:8] rand_key
  logic        s_tlast = 1'b0;
  logic [0:0]  s_tuser = '0;    // [0] first_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;
  logic [0:0]  m_tuser;         // [0] checksum_ok
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  codec_scoreboard sb = new();

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int bytes_sent    = 0;

  in_item_t  seen_in;
  out_item_t seen_out;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rolling_xor_packet_codec dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // monitor: register writes, input and result transfers, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        sb.apply_setting(cfg_index_t'(cfg_index), cfg_data);
      end
      if (s_tvalid && s_tready) begin
        seen_in.data_byte  = s_tdata[7:0];
        seen_in.rand_key   = s_tdata[15:8];
        seen_in.first_byte = s_tuser[0];
        seen_in.last_byte  = s_tlast;
        sb.note_input(seen_in);
      end
      if (m_tvalid && m_tready) begin
        seen_out.out_byte      = m_tdata;
        seen_out.end_of_packet = m_tlast;
        seen_out.checksum_ok   = m_tuser[0];
        sb.check_result(seen_out);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one byte after a random gap and wait for its transfer
  task automatic offer_byte(logic [7:0] data, logic first, logic last, logic [7:0] rkey);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rkey, data};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // stop offering, wait for every expected result, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_settings(logic [7:0] fkey, logic decode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIXED_KEY;
    cfg_data  <= fkey;
    @(posedge clk);
    cfg_index <= CFG_DECODE_MODE;
    cfg_data  <= {7'd0, decode};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checksum byte then payload; in decode mode the plain bytes are enciphered
  // first so that a well-formed packet decodes back to a valid checksum
  task automatic send_packet(int len, bit good, bit terminated);
    logic [7:0]   plain[$];
    logic [7:0]   rkey, sum, data;
    chain_state_t scratch;
    in_item_t     item;
    out_item_t    enc;
    rkey    = 8'($urandom);
    sum     = '0;
    scratch = '{default: '0};
    plain.push_back(8'd0);
    for (int i = 1; i < len; i++) begin
      plain.push_back(8'($urandom));
      sum = sum + plain[i];
    end
    plain[0] = good ? sum : 8'($urandom);
    for (int i = 0; i < len; i++) begin
      item.data_byte  = plain[i];
      item.first_byte = (i == 0);
      item.last_byte  = terminated && (i == len - 1);
      item.rand_key   = (i == 0) ? rkey : 8'($urandom);
      data = plain[i];
      if (sb.decode_mode) begin
        enc  = sb.code_byte(scratch, item, 1'b0, sb.fixed_key);
        data = enc.out_byte;
      end
      offer_byte(data, item.first_byte, item.last_byte, item.rand_key);
    end
  endtask

  initial begin
    int         pick;
    logic [7:0] fkey;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: stray bytes after reset, single-byte packets
    offer_byte(8'h00, 1'b0, 1'b0, 8'hFF);
    offer_byte(8'hFF, 1'b0, 1'b1, 8'h00);
    offer_byte(8'h00, 1'b1, 1'b1, 8'hFF);
    offer_byte(8'hFF, 1'b1, 1'b1, 8'h00);
    // good packet, payload sum wraps
    offer_byte(8'hFE, 1'b1, 1'b0, 8'h5A);
    offer_byte(8'h80, 1'b0, 1'b0, 8'h00);
    offer_byte(8'h7F, 1'b0, 1'b0, 8'hFF);
    offer_byte(8'hFF, 1'b0, 1'b1, 8'h00);
    // new packet starts before the last one ended
    offer_byte(8'h10, 1'b1, 1'b0, 8'h11);
    offer_byte(8'h22, 1'b0, 1'b0, 8'h00);
    offer_byte(8'h33, 1'b1, 1'b0, 8'h44);
    offer_byte(8'h33, 1'b0, 1'b1, 8'h00);
    // bytes after a last byte keep the chains running
    offer_byte(8'hA5, 1'b0, 1'b0, 8'h00);
    offer_byte(8'h5A, 1'b0, 1'b0, 8'hFF);
    // mode and key change in the middle of a packet
    offer_byte(8'h12, 1'b1, 1'b0, 8'h34);
    offer_byte(8'h56, 1'b0, 1'b0, 8'h00);
    drain_results();
    write_settings(8'hFF, 1'b1);
    offer_byte(8'h9A, 1'b0, 1'b1, 8'h00);
    drain_results();

    // random phases over key settings, both modes and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      case (ph)
        0, 3: fkey = 8'hFF;
        1, 4: fkey = 8'h00;
        default: fkey = 8'($urandom);
      endcase
      write_settings(fkey, ph[0]);
      // long receiver hold-off while the sender keeps offering
      if (ph == 2 || ph == 6) begin
        hold_requests++;
      end
      pick = bytes_sent;
      // long packet so the byte index wraps
      if (ph == 1 || ph == 4) begin
        send_packet(260, 1'b1, 1'b1);
      end
      while (bytes_sent - pick < PhaseItems) begin
        case ($urandom_range(19))
          0, 1: send_packet($urandom_range(1, 8), 1'($urandom_range(1)), 1'b0);
          2: offer_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom));
          3: send_packet($urandom_range(13, 40), $urandom_range(3) != 0, 1'b1);
          default: send_packet($urandom_range(1, 12), $urandom_range(3) != 0, 1'b1);
        endcase
      end
      drain_results();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
